// ===== src/gmwp_pkg.sv =====
// Shared types and constants for the grid max-weight path search block.
// No dependencies; every other file refers to this package by scoped names.
package gmwp_pkg;

    localparam int MAX_DIM_DEF   = 16;
    localparam int CELL_BITS_DEF = 8;
    localparam int IN_W          = 8;   // cell_weight field width
    localparam int OUT_W         = 16;  // best_total field width
    localparam int CFG_W         = 5;   // widest configuration register
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_START,
        ST_START_W,
        ST_STEP,
        ST_NB_W,
        ST_POP_W,
        ST_DONE
    } t_eng_state;

    // Neighbor order: row+1, row-1, col-1, col+1, then exhausted.
    localparam logic [2:0] DIR_ROW_INC = 3'd0;
    localparam logic [2:0] DIR_ROW_DEC = 3'd1;
    localparam logic [2:0] DIR_COL_DEC = 3'd2;
    localparam logic [2:0] DIR_COL_INC = 3'd3;
    localparam logic [2:0] DIR_END     = 3'd4;

    typedef struct packed {
        logic            wr_en;
        logic [IN_W-1:0] weight;
        logic            last;
        logic            res_take;
    } t_eng_ctl;

    typedef struct packed {
        logic             idle;
        logic             res_valid;
        logic [OUT_W-1:0] res_total;
    } t_eng_sts;

endpackage

// ===== src/gmwp_in_if.sv =====
// Input channel for cell weights: valid/ready handshake plus payload.
// Depends on gmwp_pkg for the field width.
interface gmwp_in_if;
    logic                       valid;
    logic                       ready;
    logic [gmwp_pkg::IN_W-1:0]  cell_weight;
    logic                       last_cell;

    modport source (output valid, output cell_weight, output last_cell, input ready);
    modport sink   (input valid, input cell_weight, input last_cell, output ready);
endinterface

// ===== src/gmwp_out_if.sv =====
// Result channel carrying the best path total: valid/ready handshake plus payload.
// Depends on gmwp_pkg for the field width.
interface gmwp_out_if;
    logic                       valid;
    logic                       ready;
    logic [gmwp_pkg::OUT_W-1:0] best_total;

    modport source (output valid, output best_total, input ready);
    modport sink   (input valid, input best_total, output ready);
endinterface

// ===== src/grid_max_weight_path_search_core.sv =====
// Top level of the grid max-weight path search: configuration registers,
// channel handshakes and result register. Depends on gmwp_pkg, gmwp_in_if,
// gmwp_out_if and gmwp_engine.
//
//   channel    dir  beat payload                  notes
//   i_cell     in   cell_weight[7:0], last_cell    one grid cell per beat
//   o_result   out  best_total[15:0]               one beat per last_cell
//   i_cfg_*    in   index 0 num_rows, 1 num_cols   write only, no wait
//
// i_cell.ready stays high while loading, so every valid beat stores a cell.
// After the last cell the search runs: each start cell is read in ST_START
// and checked in ST_START_W; each stack step in ST_STEP adds an ST_NB_W wait
// for each in-bounds neighbor probe and an ST_POP_W wait for each non-root
// pop, set by the registered reads of the weight, visited and stack memories.
// Total time grows exponentially with the number of nonzero cells. After
// reset a clearing pass sweeps the visited memory before any beat is taken.
// A finished result waits in the output register; loading resumes meanwhile.
module grid_max_weight_path_search_core #(
    parameter int MAX_DIM   = gmwp_pkg::MAX_DIM_DEF,
    parameter int CELL_BITS = gmwp_pkg::CELL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gmwp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gmwp_pkg::CFG_W-1:0]     i_cfg_data,
    gmwp_in_if.sink                        i_cell,
    gmwp_out_if.source                     o_result
);

    logic [gmwp_pkg::CFG_W-1:0] r_num_rows, r_num_cols;
    logic                       r_out_valid;
    logic [gmwp_pkg::OUT_W-1:0] r_out_total;
    logic                       take;
    gmwp_pkg::t_eng_ctl         ctl;
    gmwp_pkg::t_eng_sts         sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= gmwp_pkg::DIM_RESET;
            r_num_cols <= gmwp_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (gmwp_pkg::t_cfg_reg'(i_cfg_idx))
                gmwp_pkg::CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                gmwp_pkg::CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                default:                r_num_rows <= r_num_rows;
            endcase
        end
    end

    assign i_cell.ready = sts.idle;

    // Move a finished result into the output register when it is free
    assign take = sts.res_valid && (!r_out_valid || o_result.ready);

    always_comb begin
        ctl.wr_en    = i_cell.valid && sts.idle;
        ctl.weight   = i_cell.cell_weight;
        ctl.last     = i_cell.last_cell;
        ctl.res_take = take;
    end

    gmwp_engine #(
        .MAX_DIM   (MAX_DIM),
        .CELL_BITS (CELL_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_num_rows (r_num_rows),
        .i_num_cols (r_num_cols),
        .o_sts      (sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out_total <= sts.res_total;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.best_total = r_out_total;

endmodule

// ===== src/gmwp_engine.sv =====
// Search engine: weight, visited and path stack memories with the sequencer
// that loads cells and runs the backtracking walk. Depends on gmwp_pkg.
module gmwp_engine #(
    parameter int MAX_DIM   = gmwp_pkg::MAX_DIM_DEF,
    parameter int CELL_BITS = gmwp_pkg::CELL_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gmwp_pkg::t_eng_ctl         i_ctl,
    input  logic [gmwp_pkg::CFG_W-1:0] i_num_rows,
    input  logic [gmwp_pkg::CFG_W-1:0] i_num_cols,
    output gmwp_pkg::t_eng_sts         o_sts
);

    localparam int NCELLS = MAX_DIM * MAX_DIM;
    localparam int CIDX_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CNT_W  = $clog2(NCELLS + 1);
    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DCNT_W = $clog2(MAX_DIM + 1);
    localparam int SUM_W  = CELL_BITS + CIDX_W;
    localparam int ENT_W  = CIDX_W + 2 * DIM_W + 3 + CELL_BITS;
    localparam int SAT_W  = (SUM_W > gmwp_pkg::OUT_W) ? SUM_W : gmwp_pkg::OUT_W + 1;

    function automatic logic [DCNT_W-1:0] clamp_dim(input logic [gmwp_pkg::CFG_W-1:0] v);
        logic [DCNT_W-1:0] res;
        if (v == '0) begin
            res = DCNT_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            res = DCNT_W'(MAX_DIM);
        end else begin
            res = DCNT_W'(v);
        end
        return res;
    endfunction

    gmwp_pkg::t_eng_state r_state, n_state;

    logic [DCNT_W-1:0]    rows, cols;
    logic [CNT_W-1:0]     cells;

    logic [CIDX_W-1:0]    r_ld, n_ld;
    logic [CIDX_W-1:0]    r_clr, n_clr;
    logic [CNT_W-1:0]     r_start, n_start;
    logic [DIM_W-1:0]     r_srow, n_srow, r_scol, n_scol;
    logic [CNT_W-1:0]     r_depth, n_depth;
    logic [SUM_W-1:0]     r_run, n_run, r_best, n_best;

    logic [CIDX_W-1:0]    r_top_cell, n_top_cell;
    logic [DIM_W-1:0]     r_top_row, n_top_row, r_top_col, n_top_col;
    logic [2:0]           r_top_dir, n_top_dir;
    logic [CELL_BITS-1:0] r_top_w, n_top_w;
    logic [CIDX_W-1:0]    r_nb_cell, n_nb_cell;
    logic [DIM_W-1:0]     r_nb_row, n_nb_row, r_nb_col, n_nb_col;

    logic [CELL_BITS-1:0] r_wmem [NCELLS];
    logic                 r_vmem [NCELLS];
    logic [ENT_W-1:0]     r_smem [NCELLS];
    logic [CELL_BITS-1:0] r_w_rd;
    logic                 r_v_rd;
    logic [ENT_W-1:0]     r_s_rd;

    logic                 w_we, v_we, v_wd, s_we;
    logic [CIDX_W-1:0]    w_wa, w_ra, v_wa, v_ra, s_wa, s_ra;
    logic [CELL_BITS-1:0] w_wd;
    logic [ENT_W-1:0]     s_wd;

    // Load position
    logic [CELL_BITS-1:0] wt;
    logic [CIDX_W-1:0]    ld_fix, ld_nx;
    logic [CNT_W-1:0]     ld_inc;

    // Start scan
    logic [CIDX_W-1:0]    start_cell;
    logic                 start_end;
    logic [DCNT_W-1:0]    scol_inc;
    logic [DIM_W-1:0]     adv_row, adv_col;

    // Neighbor of the top of stack
    logic                 nb_ok;
    logic [CIDX_W-1:0]    nb_cell;
    logic [DIM_W-1:0]     nb_row, nb_col;
    logic [DCNT_W-1:0]    row_inc, col_inc;

    logic [SUM_W-1:0]     push_sum;
    logic                 push_nb;
    logic [CNT_W-1:0]     dm1, dm2;
    logic [SAT_W-1:0]     best_ext;

    assign rows  = clamp_dim(i_num_rows);
    assign cols  = clamp_dim(i_num_cols);
    assign cells = CNT_W'(rows) * CNT_W'(cols);

    assign wt     = CELL_BITS'(i_ctl.weight);
    assign ld_fix = (CNT_W'(r_ld) >= cells) ? '0 : r_ld;
    assign ld_inc = CNT_W'(ld_fix) + CNT_W'(1);
    assign ld_nx  = (ld_inc >= cells) ? '0 : ld_inc[CIDX_W-1:0];

    assign start_cell = r_start[CIDX_W-1:0];
    assign start_end  = (r_start == cells);
    assign scol_inc   = DCNT_W'(r_scol) + DCNT_W'(1);
    assign adv_row    = (scol_inc == cols) ? r_srow + DIM_W'(1) : r_srow;
    assign adv_col    = (scol_inc == cols) ? '0 : scol_inc[DIM_W-1:0];

    assign row_inc = DCNT_W'(r_top_row) + DCNT_W'(1);
    assign col_inc = DCNT_W'(r_top_col) + DCNT_W'(1);

    assign push_sum = r_run + SUM_W'(r_w_rd);
    assign push_nb  = (r_w_rd != '0) && !r_v_rd;
    assign dm1      = r_depth - CNT_W'(1);
    assign dm2      = r_depth - CNT_W'(2);
    assign best_ext = SAT_W'(r_best);

    always_comb begin
        nb_ok   = 1'b0;
        nb_cell = r_top_cell;
        nb_row  = r_top_row;
        nb_col  = r_top_col;
        case (r_top_dir)
            gmwp_pkg::DIR_ROW_INC: begin
                nb_ok   = (row_inc < rows);
                nb_row  = row_inc[DIM_W-1:0];
                nb_cell = r_top_cell + CIDX_W'(cols);
            end
            gmwp_pkg::DIR_ROW_DEC: begin
                nb_ok   = (r_top_row != '0);
                nb_row  = r_top_row - DIM_W'(1);
                nb_cell = r_top_cell - CIDX_W'(cols);
            end
            gmwp_pkg::DIR_COL_DEC: begin
                nb_ok   = (r_top_col != '0);
                nb_col  = r_top_col - DIM_W'(1);
                nb_cell = r_top_cell - CIDX_W'(1);
            end
            gmwp_pkg::DIR_COL_INC: begin
                nb_ok   = (col_inc < cols);
                nb_col  = col_inc[DIM_W-1:0];
                nb_cell = r_top_cell + CIDX_W'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gmwp_pkg::ST_CLEAR: begin
                if (r_clr == CIDX_W'(NCELLS - 1)) n_state = gmwp_pkg::ST_LOAD;
            end
            gmwp_pkg::ST_LOAD: begin
                if (i_ctl.wr_en && i_ctl.last) n_state = gmwp_pkg::ST_START;
            end
            gmwp_pkg::ST_START: begin
                n_state = start_end ? gmwp_pkg::ST_DONE : gmwp_pkg::ST_START_W;
            end
            gmwp_pkg::ST_START_W: begin
                n_state = (r_w_rd == '0) ? gmwp_pkg::ST_START : gmwp_pkg::ST_STEP;
            end
            gmwp_pkg::ST_STEP: begin
                if (r_top_dir == gmwp_pkg::DIR_END) begin
                    n_state = (r_depth == CNT_W'(1)) ? gmwp_pkg::ST_START
                                                     : gmwp_pkg::ST_POP_W;
                end else if (nb_ok) begin
                    n_state = gmwp_pkg::ST_NB_W;
                end
            end
            gmwp_pkg::ST_NB_W:  n_state = gmwp_pkg::ST_STEP;
            gmwp_pkg::ST_POP_W: n_state = gmwp_pkg::ST_STEP;
            gmwp_pkg::ST_DONE: begin
                if (i_ctl.res_take) n_state = gmwp_pkg::ST_LOAD;
            end
            default: n_state = gmwp_pkg::ST_CLEAR;
        endcase
    end

    // Datapath, memory ports and status
    always_comb begin
        n_ld       = r_ld;
        n_clr      = r_clr;
        n_start    = r_start;
        n_srow     = r_srow;
        n_scol     = r_scol;
        n_depth    = r_depth;
        n_run      = r_run;
        n_best     = r_best;
        n_top_cell = r_top_cell;
        n_top_row  = r_top_row;
        n_top_col  = r_top_col;
        n_top_dir  = r_top_dir;
        n_top_w    = r_top_w;
        n_nb_cell  = r_nb_cell;
        n_nb_row   = r_nb_row;
        n_nb_col   = r_nb_col;

        w_we = 1'b0;
        w_wa = ld_fix;
        w_wd = wt;
        w_ra = start_cell;
        v_we = 1'b0;
        v_wa = r_top_cell;
        v_wd = 1'b0;
        v_ra = nb_cell;
        s_we = 1'b0;
        s_wa = dm1[CIDX_W-1:0];
        s_wd = {r_top_cell, r_top_row, r_top_col, r_top_dir, r_top_w};
        s_ra = dm2[CIDX_W-1:0];

        unique case (r_state)
            gmwp_pkg::ST_CLEAR: begin
                v_we  = 1'b1;
                v_wa  = r_clr;
                n_clr = r_clr + CIDX_W'(1);
            end
            gmwp_pkg::ST_LOAD: begin
                if (i_ctl.wr_en) begin
                    w_we = 1'b1;
                    if (i_ctl.last) begin
                        n_ld    = '0;
                        n_start = '0;
                        n_srow  = '0;
                        n_scol  = '0;
                        n_best  = '0;
                    end else begin
                        n_ld = ld_nx;
                    end
                end
            end
            gmwp_pkg::ST_START: begin
                w_ra = start_cell;
            end
            gmwp_pkg::ST_START_W: begin
                if (r_w_rd == '0) begin
                    n_start = r_start + CNT_W'(1);
                    n_srow  = adv_row;
                    n_scol  = adv_col;
                end else begin
                    // Open a new walk rooted at this cell
                    n_top_cell = start_cell;
                    n_top_row  = r_srow;
                    n_top_col  = r_scol;
                    n_top_dir  = gmwp_pkg::DIR_ROW_INC;
                    n_top_w    = r_w_rd;
                    n_depth    = CNT_W'(1);
                    n_run      = push_sum;
                    n_best     = (push_sum > r_best) ? push_sum : r_best;
                    v_we       = 1'b1;
                    v_wa       = start_cell;
                    v_wd       = 1'b1;
                end
            end
            gmwp_pkg::ST_STEP: begin
                if (r_top_dir == gmwp_pkg::DIR_END) begin
                    // Drop the top cell and unmark it
                    v_we    = 1'b1;
                    v_wa    = r_top_cell;
                    n_run   = r_run - SUM_W'(r_top_w);
                    n_depth = dm1;
                    if (r_depth == CNT_W'(1)) begin
                        n_start = r_start + CNT_W'(1);
                        n_srow  = adv_row;
                        n_scol  = adv_col;
                    end
                end else begin
                    n_top_dir = r_top_dir + 3'd1;
                    w_ra      = nb_cell;
                    v_ra      = nb_cell;
                    n_nb_cell = nb_cell;
                    n_nb_row  = nb_row;
                    n_nb_col  = nb_col;
                end
            end
            gmwp_pkg::ST_NB_W: begin
                if (push_nb) begin
                    s_we       = 1'b1;
                    n_top_cell = r_nb_cell;
                    n_top_row  = r_nb_row;
                    n_top_col  = r_nb_col;
                    n_top_dir  = gmwp_pkg::DIR_ROW_INC;
                    n_top_w    = r_w_rd;
                    n_depth    = r_depth + CNT_W'(1);
                    n_run      = push_sum;
                    n_best     = (push_sum > r_best) ? push_sum : r_best;
                    v_we       = 1'b1;
                    v_wa       = r_nb_cell;
                    v_wd       = 1'b1;
                end
            end
            gmwp_pkg::ST_POP_W: begin
                {n_top_cell, n_top_row, n_top_col, n_top_dir, n_top_w} = r_s_rd;
            end
            gmwp_pkg::ST_DONE: begin
                n_ld = '0;
            end
            default: begin
                n_ld = r_ld;
            end
        endcase

        o_sts.idle      = (r_state == gmwp_pkg::ST_LOAD);
        o_sts.res_valid = (r_state == gmwp_pkg::ST_DONE);
        o_sts.res_total = (best_ext > SAT_W'({gmwp_pkg::OUT_W{1'b1}}))
                          ? {gmwp_pkg::OUT_W{1'b1}} : best_ext[gmwp_pkg::OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmwp_pkg::ST_CLEAR;
            r_ld    <= '0;
            r_clr   <= '0;
            r_start <= '0;
            r_depth <= '0;
            r_run   <= '0;
            r_best  <= '0;
        end else begin
            r_state <= n_state;
            r_ld    <= n_ld;
            r_clr   <= n_clr;
            r_start <= n_start;
            r_depth <= n_depth;
            r_run   <= n_run;
            r_best  <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srow     <= n_srow;
        r_scol     <= n_scol;
        r_top_cell <= n_top_cell;
        r_top_row  <= n_top_row;
        r_top_col  <= n_top_col;
        r_top_dir  <= n_top_dir;
        r_top_w    <= n_top_w;
        r_nb_cell  <= n_nb_cell;
        r_nb_row   <= n_nb_row;
        r_nb_col   <= n_nb_col;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_wmem[w_wa] <= w_wd;
        r_w_rd <= r_wmem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_vmem[v_wa] <= v_wd;
        r_v_rd <= r_vmem[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) r_smem[s_wa] <= s_wd;
        r_s_rd <= r_smem[s_ra];
    end

    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmwp_pkg::ST_LOAD) |-> (r_depth == '0 && r_run == '0))
        else $error("stack or running sum not empty while loading");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best >= r_run)
        else $error("best total fell below running sum");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= cells)
        else $error("path stack deeper than grid");

    a_root_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gmwp_pkg::ST_STEP && r_top_dir == gmwp_pkg::DIR_END &&
         r_depth == CNT_W'(1)) |=> (r_run == '0 && r_depth == '0))
        else $error("running sum not zero after root pop");

endmodule

// ===== tb/tb_grid_max_weight_path_search_core.sv =====
// Self-checking testbench for grid_max_weight_path_search_core: streams cell grids,
// predicts each best path total and compares every result beat.
// Depends on gmwp_pkg, gmwp_in_if, gmwp_out_if and the core under test.
`timescale 1ns / 1ps

module tb_grid_max_weight_path_search_core;

    localparam int CLK_PERIOD    = 12;
    localparam int DIM           = gmwp_pkg::MAX_DIM_DEF;
    localparam int CFG_W         = gmwp_pkg::CFG_W;
    localparam int CFG_IDX_W     = gmwp_pkg::CFG_IDX_W;
    localparam int IN_W          = gmwp_pkg::IN_W;
    localparam int OUT_W         = gmwp_pkg::OUT_W;
    localparam int IDLE_PCT      = 24;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 32;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int ITEM_GOAL     = 1000;
    localparam int SEARCH_GOAL   = 40;
    localparam int SPARSE_CAP    = 8;
    localparam int PLAN_LEN      = 29;

    typedef enum {FILL_DENSE, FILL_SPARSE, FILL_MAX, FILL_ZERO} t_fill;

    typedef struct packed {
        logic             is_cfg;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic [IN_W-1:0]  weight;
        logic             last;
        logic             has_typed;
        logic [OUT_W-1:0] typed;
    } t_plan_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    gmwp_in_if  cell_ch ();
    gmwp_out_if res_ch ();

    grid_max_weight_path_search_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cell     (cell_ch),
        .o_result   (res_ch)
    );

    // Shadow of the block: weights, load position and dimension registers.
    logic [IN_W-1:0]  grid_w [0:DIM*DIM-1];
    int unsigned      load_pos;
    logic [CFG_W-1:0] reg_rows;
    logic [CFG_W-1:0] reg_cols;

    logic [OUT_W-1:0] totals_due [$];
    logic [OUT_W-1:0] want;
    int               errors;
    int               results_checked;
    int               cells_sent;
    int               searches;
    int               cycle_count;
    bit               steady;

    t_plan_row        plan [0:PLAN_LEN-1];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned dim_used(logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM) return DIM;
        return v;
    endfunction

    // Exhaustive walk over simple 4-neighbor paths through nonzero cells.
    function automatic int unsigned longest_path_total(int unsigned nr, int unsigned nc);
        bit          on_path [0:DIM*DIM-1];
        int unsigned trail_cell [0:DIM*DIM-1];
        logic [2:0]  trail_dir [0:DIM*DIM-1];
        int unsigned depth, sum, best, here, nb, s;
        int          row, col;
        logic [2:0]  dir;
        best = 0;
        for (s = 0; s < nr * nc; s++) begin
            if (grid_w[s] == '0) continue;
            foreach (on_path[k]) on_path[k] = 1'b0;
            trail_cell[0] = s;
            trail_dir[0]  = gmwp_pkg::DIR_ROW_INC;
            on_path[s]    = 1'b1;
            depth         = 1;
            sum           = grid_w[s];
            if (sum > best) best = sum;
            while (depth > 0) begin
                here = trail_cell[depth-1];
                dir  = trail_dir[depth-1];
                if (dir >= gmwp_pkg::DIR_END) begin
                    // backtrack
                    on_path[here] = 1'b0;
                    sum -= grid_w[here];
                    depth--;
                end else begin
                    trail_dir[depth-1] = dir + 3'd1;
                    row = here / nc;
                    col = here % nc;
                    case (dir)
                        gmwp_pkg::DIR_ROW_INC: row++;
                        gmwp_pkg::DIR_ROW_DEC: row--;
                        gmwp_pkg::DIR_COL_DEC: col--;
                        default:               col++;
                    endcase
                    if (row >= 0 && col >= 0 && row < int'(nr) && col < int'(nc)) begin
                        nb = row * nc + col;
                        if (grid_w[nb] != '0 && !on_path[nb]) begin
                            trail_cell[depth] = nb;
                            trail_dir[depth]  = gmwp_pkg::DIR_ROW_INC;
                            on_path[nb]       = 1'b1;
                            depth++;
                            sum += grid_w[nb];
                            if (sum > best) best = sum;
                        end
                    end
                end
            end
        end
        return (best > 16'hFFFF) ? 16'hFFFF : best;
    endfunction

    // Store one cell; on the final cell run the search and return its total.
    function automatic bit absorb_cell(logic [IN_W-1:0] w, bit last,
                                       output logic [OUT_W-1:0] total);
        int unsigned nr, nc, n;
        nr = dim_used(reg_rows);
        nc = dim_used(reg_cols);
        n  = nr * nc;
        if (load_pos >= n) load_pos = 0;
        grid_w[load_pos] = w;
        load_pos++;
        if (load_pos >= n) load_pos = 0;
        total = '0;
        if (!last) return 1'b0;
        load_pos = 0;
        total = OUT_W'(longest_path_total(nr, nc));
        return 1'b1;
    endfunction

    // Register value for a dimension, sometimes as an out-of-range alias.
    function automatic logic [CFG_W-1:0] dim_code(int unsigned d);
        if (d == 1 && $urandom_range(3) == 0) return '0;
        if (d == DIM && $urandom_range(1) == 0) return CFG_W'($urandom_range(31, DIM + 1));
        return CFG_W'(d);
    endfunction

    task automatic send_cell(logic [IN_W-1:0] w, bit last, bit has_typed,
                             logic [OUT_W-1:0] typed);
        int               gap;
        logic [OUT_W-1:0] total;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cell_ch.valid       <= 1'b1;
        cell_ch.cell_weight <= w;
        cell_ch.last_cell   <= last;
        do @(posedge i_clk); while (!cell_ch.ready);
        cells_sent++;
        if (absorb_cell(w, last, total)) begin
            searches++;
            totals_due.push_back(has_typed ? typed : total);
        end
    endtask

    // Drop valid and wait until the block has nothing left to deliver.
    task automatic settle();
        cell_ch.valid <= 1'b0;
        while (totals_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= gmwp_pkg::CFG_NUM_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        reg_rows   = rows;
        i_cfg_idx  <= gmwp_pkg::CFG_NUM_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        reg_cols   = cols;
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_grid(int n, t_fill fill);
        int              k, nz_left;
        logic [IN_W-1:0] w;
        nz_left = SPARSE_CAP;
        for (k = 0; k < n; k++) begin
            case (fill)
                FILL_DENSE:
                    w = ($urandom_range(3) == 0) ? '0 : IN_W'($urandom_range(255, 1));
                FILL_SPARSE: begin
                    w = '0;
                    if (nz_left > 0 && $urandom_range(n - 1) < SPARSE_CAP) begin
                        w = IN_W'($urandom_range(255, 1));
                        nz_left--;
                    end
                end
                FILL_MAX: w = '1;
                default:  w = '0;
            endcase
            send_cell(w, k == n - 1, 1'b0, '0);
        end
    endtask

    // Small grids only: the search is exponential in nonzero cells.
    task automatic pick_small(output int unsigned nr, output int unsigned nc);
        nr = $urandom_range(9, 1);
        nc = $urandom_range(9 / nr, 1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (totals_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual best_total=%0d",
                             $time, res_ch.best_total);
                    errors++;
                end else begin
                    want = totals_due.pop_front();
                    results_checked++;
                    if (res_ch.best_total !== want) begin
                        $display("%0t: best_total mismatch, expected %0d actual %0d",
                                 $time, want, res_ch.best_total);
                        errors++;
                    end
                end
            end
            res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL grid_max_weight_path_search_core");
        $finish;
    end

    initial begin
        int unsigned nr, nc, cur_cells, p, grid_no, pick, i;
        t_fill       cur_fill;

        i_clk = 1'b0;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= gmwp_pkg::CFG_NUM_ROWS;
        i_cfg_data          <= '0;
        cell_ch.valid       <= 1'b0;
        cell_ch.cell_weight <= '0;
        cell_ch.last_cell   <= 1'b0;
        errors          = 0;
        results_checked = 0;
        cells_sent      = 0;
        searches        = 0;
        steady          = 1'b0;
        load_pos        = 0;
        reg_rows        = gmwp_pkg::DIM_RESET;
        reg_cols        = gmwp_pkg::DIM_RESET;
        foreach (grid_w[k]) grid_w[k] = '0;

        //         cfg  rows   cols   weight   last typed value
        plan = '{
            '{1'b1, 5'd1,  5'd1,  8'd0,    1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd0,    1'b1, 1'b1, 16'd0},    // all-zero grid
            '{1'b0, 5'd0,  5'd0,  8'd255,  1'b1, 1'b1, 16'd255},
            '{1'b1, 5'd0,  5'd2,  8'd0,    1'b0, 1'b0, 16'd0},    // zero rows reads as one
            '{1'b0, 5'd0,  5'd0,  8'd255,  1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd255,  1'b1, 1'b1, 16'd510},
            '{1'b0, 5'd0,  5'd0,  8'd10,   1'b0, 1'b0, 16'd0},    // extra cell wraps to 0
            '{1'b0, 5'd0,  5'd0,  8'd20,   1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd30,   1'b1, 1'b1, 16'd50},
            '{1'b0, 5'd0,  5'd0,  8'd5,    1'b0, 1'b0, 16'd0},    // partial grid
            '{1'b1, 5'd1,  5'd0,  8'd0,    1'b0, 1'b0, 16'd0},    // shrink past load position
            '{1'b0, 5'd0,  5'd0,  8'd9,    1'b1, 1'b1, 16'd9},
            '{1'b1, 5'd31, 5'd1,  8'd0,    1'b0, 1'b0, 16'd0},    // rows clamp to max
            '{1'b0, 5'd0,  5'd0,  8'd200,  1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd17,   1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd0,    1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd128,  1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd255,  1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd64,   1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd1,    1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd2,    1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd4,    1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd8,    1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd16,   1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd32,   1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd0,    1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd127,  1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd254,  1'b0, 1'b0, 16'd0},
            '{1'b0, 5'd0,  5'd0,  8'd99,   1'b1, 1'b0, 16'd0}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].is_cfg) begin
                settle();
                set_dims(plan[i].rows, plan[i].cols);
            end else begin
                send_cell(plan[i].weight, plan[i].last, plan[i].has_typed, plan[i].typed);
            end
        end

        cur_cells = DIM;
        cur_fill  = FILL_DENSE;
        grid_no   = 0;
        while (cells_sent < ITEM_GOAL || searches < SEARCH_GOAL) begin
            steady = (grid_no >= 12 && grid_no < 24);
            if ($urandom_range(99) < 30) begin
                // same size, load right behind the pending search
                send_grid(cur_cells, cur_fill);
            end else begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    pick_small(nr, nc);
                    case ($urandom_range(19))
                        0:       cur_fill = FILL_ZERO;
                        1, 2:    cur_fill = FILL_MAX;
                        default: cur_fill = FILL_DENSE;
                    endcase
                    settle();
                    set_dims(dim_code(nr), dim_code(nc));
                    cur_cells = nr * nc;
                    send_grid(cur_cells, cur_fill);
                end else if (pick < 70) begin
                    p  = $urandom_range(DIM, 1);
                    nr = $urandom_range(1) ? p : 1;
                    nc = (nr == 1) ? p : 1;
                    cur_fill = ($urandom_range(3) == 0) ? FILL_MAX : FILL_DENSE;
                    settle();
                    set_dims(dim_code(nr), dim_code(nc));
                    cur_cells = nr * nc;
                    send_grid(cur_cells, cur_fill);
                end else if (pick < 85) begin
                    if ($urandom_range(7) == 0) begin
                        nr = DIM;
                        nc = DIM;
                    end else begin
                        nr = $urandom_range(DIM, 1);
                        nc = $urandom_range(DIM, 1);
                    end
                    cur_fill = FILL_SPARSE;
                    settle();
                    set_dims(dim_code(nr), dim_code(nc));
                    cur_cells = nr * nc;
                    send_grid(cur_cells, cur_fill);
                end else if (pick < 93) begin
                    // overlong grid: extra cells overwrite from the start
                    pick_small(nr, nc);
                    cur_fill = FILL_DENSE;
                    settle();
                    set_dims(dim_code(nr), dim_code(nc));
                    cur_cells = nr * nc;
                    send_grid(cur_cells + $urandom_range(cur_cells, 1), cur_fill);
                end else begin
                    // abandon a partial grid, resize, then load a full one
                    p = $urandom_range((cur_cells < 12) ? cur_cells : 12, 1);
                    for (i = 0; i < p; i++)
                        send_cell(IN_W'($urandom_range(255)), 1'b0, 1'b0, '0);
                    pick_small(nr, nc);
                    cur_fill = FILL_DENSE;
                    settle();
                    set_dims(dim_code(nr), dim_code(nc));
                    cur_cells = nr * nc;
                    send_grid(cur_cells, cur_fill);
                end
            end
            grid_no++;
        end

        steady = 1'b0;
        cell_ch.valid <= 1'b0;
        while (totals_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Loaded %0d cells over %0d grid searches; %0d best totals compared.",
                 cells_sent, searches, results_checked);
        $display("Grids ranged from single cells to 16x16 with wraps, resizes and clamped sizes.");
        if (errors == 0 && totals_due.size() == 0) begin
            $display("PASS grid_max_weight_path_search_core");
        end else begin
            $display("FAIL grid_max_weight_path_search_core");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/gmwp_pkg.sv
src/gmwp_in_if.sv
src/gmwp_out_if.sv
src/gmwp_engine.sv
src/grid_max_weight_path_search_core.sv
tb/tb_grid_max_weight_path_search_core.sv
